// ===== sv/bpf_pkg.sv =====
// ----------------------------------------------------------------------------
// bpf_pkg
// Shared types, constants and the shade color table of the background
// pixel fetcher.
// ----------------------------------------------------------------------------
package bpf_pkg;

  // Visible line width in pixels; columns at or past it render nothing
  localparam int SCREEN_WIDTH = 160;

  // Video memory geometry: two byte banks split on address bit 0
  localparam int VRAM_DEPTH     = 8192;
  localparam int VRAM_AW        = 13;
  localparam int BANK_DEPTH     = VRAM_DEPTH / 2;
  localparam int BANK_AW        = VRAM_AW - 1;

  // Offsets from the start of video memory
  localparam logic [VRAM_AW-1:0] MAP_LOW_OFFSET  = 13'h1800;
  localparam logic [VRAM_AW-1:0] MAP_HIGH_OFFSET = 13'h1C00;
  localparam logic [VRAM_AW-1:0] SIGNED_BASE     = 13'h0800;

  // Input commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_LCD_CONTROL = 2'd0;
  localparam logic [1:0] REG_SCROLL_X    = 2'd1;
  localparam logic [1:0] REG_SCROLL_Y    = 2'd2;
  localparam logic [1:0] REG_BG_PALETTE  = 2'd3;

  // Control byte bits
  localparam int LCDC_MAP_SEL  = 3;
  localparam int LCDC_UNSIGNED = 4;

  typedef struct packed {
    logic                cmd;
    logic [VRAM_AW-1:0]  vram_offset;
    logic [7:0]          write_byte;
    logic [7:0]          screen_x;
    logic [7:0]          screen_line;
  } bpf_in_t;

  typedef struct packed {
    logic [1:0] shade;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } bpf_out_t;

  // One video memory access per cycle: a byte write, a map read or a row read
  typedef struct packed {
    logic                wr_en;
    logic [VRAM_AW-1:0]  wr_offset;
    logic [7:0]          wr_data;
    logic                map_rd;
    logic [VRAM_AW-1:0]  map_offset;
    logic                row_rd;
    logic [BANK_AW-1:0]  row_index;
  } bpf_vram_req_t;

  // Registered read data, valid in the cycle after the request
  typedef struct packed {
    logic [7:0] map_byte;
    logic [7:0] lo_byte;
    logic [7:0] hi_byte;
  } bpf_vram_rsp_t;

  // Green shade table: {red, green, blue}
  function automatic logic [23:0] shade_rgb(input logic [1:0] shade);
    logic [23:0] rgb;
    case (shade)
      2'd0:    rgb = 24'h9BBC0F;
      2'd1:    rgb = 24'h8BAC0F;
      2'd2:    rgb = 24'h306230;
      2'd3:    rgb = 24'h0F380F;
      default: rgb = 24'h9BBC0F;
    endcase
    return rgb;
  endfunction

endpackage

// ===== sv/background_pixel_fetcher_unit.sv =====
// ----------------------------------------------------------------------------
// background_pixel_fetcher_unit
// Background tile fetcher: loads video memory and renders single pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries two kinds of request.
//   A write request stores one byte into video memory when it is accepted.
//   A render request reads the tile number from the selected map in the
//   cycle it is accepted, reads both bit-planes of the tile row in the next
//   cycle (in_stall is high then, the memory port is busy), then picks the
//   pixel from both planes in the pick stage and pushes the result into the
//   output queue, which drives out_valid/out_data. No new request is taken
//   while the row read owns the single port of the video memory banks.
//   A render whose column lies past the visible line gives no result.
//   Results wait in a two-entry queue; while out_stall is high the queue
//   holds, and new requests stall once the queue plus the pick stage hold two.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while idle;
//   the user keeps to this, the block itself does not enforce it.
//   Reset clears the registers and the pipeline; video memory holds no
//   defined value until written and needs no clearing pass.
// ----------------------------------------------------------------------------
module background_pixel_fetcher_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bpf_pkg::bpf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bpf_pkg::bpf_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata
);
  import bpf_pkg::*;

  logic [7:0]    lcd_control_r;
  logic [7:0]    scroll_x_r;
  logic [7:0]    scroll_y_r;
  logic [7:0]    bg_palette_r;

  logic          in_accept;
  logic          render_go;
  logic [7:0]    px;
  logic [7:0]    py;
  logic [VRAM_AW-1:0] map_off;

  logic          s1_v_r;
  logic [2:0]    s1_px_r;
  logic [2:0]    s1_py_r;
  logic          s2_v_r;
  logic [2:0]    s2_px_r;

  logic [VRAM_AW-1:0] data_off;
  bpf_vram_req_t vram_req;
  bpf_vram_rsp_t vram_rsp;

  logic [2:0]    bit_sel;
  logic [1:0]    color_id;
  logic [7:0]    pal_shift;
  logic [1:0]    shade;
  logic [23:0]   rgb;
  bpf_out_t      result;
  logic [1:0]    q_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcd_control_r <= 8'd0;
      scroll_x_r    <= 8'd0;
      scroll_y_r    <= 8'd0;
      bg_palette_r  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LCD_CONTROL: lcd_control_r <= cfg_wdata;
        REG_SCROLL_X:    scroll_x_r    <= cfg_wdata;
        REG_SCROLL_Y:    scroll_y_r    <= cfg_wdata;
        REG_BG_PALETTE:  bg_palette_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold requests while the row read owns the port or results would overflow
  assign in_stall  = s1_v_r || ((q_count + 2'(s2_v_r)) >= 2'd2);
  assign in_accept = in_valid && !in_stall;
  assign render_go = in_accept && (in_data.cmd == CMD_RENDER) &&
                     ({1'b0, in_data.screen_x} < 9'(SCREEN_WIDTH));

  // Scroll the point and form the map entry offset
  always_comb begin
    px      = in_data.screen_x + scroll_x_r;
    py      = in_data.screen_line + scroll_y_r;
    map_off = (lcd_control_r[LCDC_MAP_SEL] ? MAP_HIGH_OFFSET : MAP_LOW_OFFSET) +
              VRAM_AW'({py[7:3], px[7:3]});
  end

  // Tile data offset from the map byte read back in stage 1
  always_comb begin
    if (lcd_control_r[LCDC_UNSIGNED]) begin
      data_off = {1'b0, vram_rsp.map_byte, 4'd0};
    end else begin
      data_off = {1'b0, ~vram_rsp.map_byte[7], vram_rsp.map_byte[6:0], 4'd0} +
                 SIGNED_BASE;
    end
  end

  // Issue the single video memory access of this cycle
  always_comb begin
    vram_req.wr_en      = in_accept && (in_data.cmd == CMD_WRITE);
    vram_req.wr_offset  = in_data.vram_offset;
    vram_req.wr_data    = in_data.write_byte;
    vram_req.map_rd     = render_go;
    vram_req.map_offset = map_off;
    vram_req.row_rd     = s1_v_r;
    vram_req.row_index  = {data_off[VRAM_AW-1:4], s1_py_r};
  end

  bpf_vram u_vram (
    .clk (clk),
    .req (vram_req),
    .rsp (vram_rsp)
  );

  // Advance the render pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= render_go;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_px_r <= px[2:0];
    s1_py_r <= py[2:0];
    s2_px_r <= s1_px_r;
  end

  // Pick the color id from both planes and map it through the palette
  always_comb begin
    bit_sel        = ~s2_px_r;
    color_id       = {vram_rsp.hi_byte[bit_sel], vram_rsp.lo_byte[bit_sel]};
    pal_shift      = bg_palette_r >> {color_id, 1'b0};
    shade          = pal_shift[1:0];
    rgb            = shade_rgb(shade);
    result.shade   = shade;
    result.red     = rgb[23:16];
    result.green   = rgb[15:8];
    result.blue    = rgb[7:0];
  end

  bpf_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_v_r),
    .push_data (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (q_count)
  );

  // Result queue never receives a push while full
  assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (q_count != 2'd2))
    else $error("result pushed into a full queue");

  // Row read stage always leads to the pick stage
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> s2_v_r)
    else $error("render lost between row read and pixel pick");

  // No request taken while the row read owns the memory port
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> !in_accept)
    else $error("request accepted during row read");

  // Accepted in-range render enters the row read stage
  assert property (@(posedge clk) disable iff (!rst_n)
    render_go |=> s1_v_r)
    else $error("accepted render did not reach row read");

endmodule

// ===== sv/bpf_ram.sv =====
// ----------------------------------------------------------------------------
// bpf_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/bpf_vram.sv =====
// ----------------------------------------------------------------------------
// bpf_vram
// Video memory as an even and an odd byte bank, so that both bit-planes of
// a tile row come back in one read.
// ----------------------------------------------------------------------------
module bpf_vram (
  input  logic                  clk,
  input  bpf_pkg::bpf_vram_req_t req,
  output bpf_pkg::bpf_vram_rsp_t rsp
);
  import bpf_pkg::*;

  logic [BANK_AW-1:0] even_addr;
  logic [BANK_AW-1:0] odd_addr;
  logic               even_we;
  logic               odd_we;
  logic [7:0]         even_rdata;
  logic [7:0]         odd_rdata;
  logic               map_odd_r;

  // Route the one access of this cycle to the banks
  always_comb begin
    if (req.row_rd) begin
      even_addr = req.row_index;
      odd_addr  = req.row_index;
    end else if (req.map_rd) begin
      even_addr = req.map_offset[VRAM_AW-1:1];
      odd_addr  = req.map_offset[VRAM_AW-1:1];
    end else begin
      even_addr = req.wr_offset[VRAM_AW-1:1];
      odd_addr  = req.wr_offset[VRAM_AW-1:1];
    end
    even_we = req.wr_en & ~req.wr_offset[0];
    odd_we  = req.wr_en &  req.wr_offset[0];
  end

  // Remember which bank holds the map byte
  always_ff @(posedge clk) begin
    map_odd_r <= req.map_offset[0];
  end

  bpf_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_even (
    .clk   (clk),
    .we    (even_we),
    .addr  (even_addr),
    .wdata (req.wr_data),
    .rdata (even_rdata)
  );

  bpf_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_odd (
    .clk   (clk),
    .we    (odd_we),
    .addr  (odd_addr),
    .wdata (req.wr_data),
    .rdata (odd_rdata)
  );

  assign rsp.map_byte = map_odd_r ? odd_rdata : even_rdata;
  assign rsp.lo_byte  = even_rdata;
  assign rsp.hi_byte  = odd_rdata;

endmodule

// ===== sv/bpf_out_queue.sv =====
// ----------------------------------------------------------------------------
// bpf_out_queue
// Two-entry result queue between the fetch pipeline and the output channel.
// ----------------------------------------------------------------------------
module bpf_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bpf_pkg::bpf_out_t push_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bpf_pkg::bpf_out_t out_data,
  output logic [1:0]        count
);
  import bpf_pkg::*;

  bpf_out_t   slot_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       pop;

  assign pop = (count_r != 2'd0) && !out_stall;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the new result
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid = (count_r != 2'd0);
  assign out_data  = slot_r[rd_ptr_r];
  assign count     = count_r;

endmodule
